>>> rtl/particle_batch_statistics_macros.svh
// ============================================================================
// particle_batch_statistics_macros: assertion macros for the checker
// Clocked, reset-qualified implication forms.
// ============================================================================
`ifndef PARTICLE_BATCH_STATISTICS_MACROS_SVH
`define PARTICLE_BATCH_STATISTICS_MACROS_SVH

// same-cycle implication, off during reset
`define PBS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pbs check failed");

// next-cycle implication, off during reset
`define PBS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pbs check failed");

// next-cycle implication that also runs through reset
`define PBS_ASSERT_RAW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("pbs check failed");

`endif

>>> rtl/pbs_pkg.sv
// ============================================================================
// pbs_pkg: shared types and constants
// Request structs, particle kinds, widths and fixed-point constants.
// ============================================================================
package pbs_pkg;

    localparam int COUNT_BITS = 20;
    localparam int SUM_W      = 52;
    localparam int ENERGY_W   = 48;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
    localparam logic [19:0]           GRAVITY_Q16 = 20'd642908;

    localparam logic [1:0] QTY_DENSITY  = 2'd0;
    localparam logic [1:0] QTY_PRESSURE = 2'd1;
    localparam logic [1:0] QTY_SPEED    = 2'd2;

    typedef enum logic [1:0] {
        KIND_NORMAL   = 2'd0,
        KIND_BOUNDARY = 2'd1,
        KIND_INACTIVE = 2'd2,
        KIND_IGNORED  = 2'd3
    } pbs_kind_t;

    typedef struct packed {
        logic [1:0]         particle_kind;
        logic signed [31:0] density;
        logic signed [31:0] pressure;
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
        logic [30:0]        mass;
        logic signed [31:0] height;
        logic               last_particle;
    } pbs_in_t;

    typedef struct packed {
        logic [1:0]                  quantity;
        logic signed [31:0]          mean_value;
        logic signed [31:0]          min_value;
        logic signed [31:0]          max_value;
        logic [COUNT_BITS-1:0]       normal_count;
        logic [COUNT_BITS-1:0]       boundary_count;
        logic [COUNT_BITS-1:0]       inactive_count;
        logic [ENERGY_W-1:0]         kinetic_total;
        logic signed [ENERGY_W-1:0]  potential_total;
        logic                        last_of_run;
    } pbs_out_t;

    // classified request handed from front to back
    typedef struct packed {
        pbs_kind_t          kind;
        logic signed [31:0] density;
        logic signed [31:0] pressure;
        logic [31:0]        abs_vx;
        logic [31:0]        abs_vy;
        logic [30:0]        mass;
        logic [31:0]        abs_h;
        logic               h_neg;
        logic               last;
    } pbs_item_t;

endpackage

>>> rtl/pbs_front.sv
// ============================================================================
// pbs_front: request intake
// Classifies each particle, takes magnitudes, and queues it (2 deep).
// ============================================================================
module pbs_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pbs_pkg::pbs_in_t    s_data,
    output logic                q_valid,
    input  logic                q_ready,
    output pbs_pkg::pbs_item_t  q_item
);
    import pbs_pkg::*;

    pbs_item_t  fifo_mem [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    pbs_item_t  item_in;
    logic       push, pop;

    always_comb begin
        item_in.kind     = pbs_kind_t'(s_data.particle_kind);
        item_in.density  = s_data.density;
        item_in.pressure = s_data.pressure;
        item_in.abs_vx   = s_data.velocity_x[31] ? (~s_data.velocity_x + 32'd1)
                                                 : s_data.velocity_x;
        item_in.abs_vy   = s_data.velocity_y[31] ? (~s_data.velocity_y + 32'd1)
                                                 : s_data.velocity_y;
        item_in.mass     = s_data.mass;
        item_in.abs_h    = s_data.height[31] ? (~s_data.height + 32'd1) : s_data.height;
        item_in.h_neg    = s_data.height[31];
        item_in.last     = s_data.last_particle;
    end

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = fifo_mem[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wr_ptr_reg] <= item_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

>>> rtl/pbs_sqrt.sv
// ============================================================================
// pbs_sqrt: iterative integer square root
// One root bit per cycle, floor result.
// ============================================================================
module pbs_sqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);
    logic        busy_reg, done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] rad_reg;
    logic [32:0] rem_reg;
    logic [31:0] root_reg;
    logic [34:0] rem_sh, trial, rem_diff;
    logic        fits;

    assign rem_sh   = {rem_reg, rad_reg[63:62]};
    assign trial    = {1'b0, root_reg, 2'b01};
    assign fits     = (rem_sh >= trial);
    assign rem_diff = fits ? (rem_sh - trial) : rem_sh;
    assign done     = done_reg;
    assign root     = root_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= 33'd0;
            root_reg <= 32'd0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            rem_reg  <= rem_diff[32:0];
            root_reg <= {root_reg[30:0], fits};
        end
    end

endmodule

>>> rtl/pbs_div.sv
// ============================================================================
// pbs_div: restoring divider
// Unsigned sum magnitude over tally, one quotient bit per cycle.
// ============================================================================
module pbs_div (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic [pbs_pkg::SUM_W-1:0]          dividend,
    input  logic [pbs_pkg::COUNT_BITS-1:0]     divisor,
    output logic                               done,
    output logic [pbs_pkg::SUM_W-1:0]          quotient
);
    import pbs_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic                  busy_reg, done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [SUM_W-1:0]      dvd_reg;
    logic [COUNT_BITS-1:0] dsr_reg, rem_reg;
    logic [COUNT_BITS:0]   rem_sh, rem_diff;
    logic                  fits;

    assign rem_sh   = {rem_reg, dvd_reg[SUM_W-1]};
    assign fits     = (rem_sh >= {1'b0, dsr_reg});
    assign rem_diff = fits ? (rem_sh - {1'b0, dsr_reg}) : rem_sh;
    assign done     = done_reg;
    assign quotient = dvd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(SUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            dsr_reg <= divisor;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[SUM_W-2:0], fits};
            rem_reg <= rem_diff[COUNT_BITS-1:0];
        end
    end

endmodule

>>> rtl/pbs_back.sv
// ============================================================================
// pbs_back: arithmetic and accumulation sequencer
// Per-particle math, running sums/min/max, batch-end mean and emission.
// ============================================================================
module pbs_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  pbs_pkg::pbs_item_t  q_item,
    output logic                m_valid,
    input  logic                m_ready,
    output pbs_pkg::pbs_out_t   m_data
);
    import pbs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SQ, ST_SUM, ST_PROD, ST_ACC, ST_SQRT_WAIT,
        ST_DIV_START, ST_DIV_WAIT, ST_EMIT
    } state_t;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [ENERGY_W-1:0]     KIN_MAX = {ENERGY_W{1'b1}};
    localparam logic signed [ENERGY_W-1:0] POT_MAX = {1'b0, {(ENERGY_W-1){1'b1}}};
    localparam logic signed [ENERGY_W-1:0] POT_MIN = {1'b1, {(ENERGY_W-1){1'b0}}};
    localparam logic signed [31:0] VAL_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] VAL_MIN = 32'sh80000000;

    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] s, input logic signed [31:0] v);
        logic signed [SUM_W:0] t;
        t = {s[SUM_W-1], s} + (SUM_W+1)'(v);
        if (t[SUM_W] != t[SUM_W-1]) begin
            return t[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return t[SUM_W-1:0];
    endfunction

    state_t                    state_reg;
    pbs_item_t                 item_reg;
    logic [63:0]               sqx_reg, sqy_reg, sq_reg;
    logic [62:0]               mh_reg, pl_reg, ph_reg;
    logic [51:0]               ql_reg;
    logic [50:0]               qh_reg;
    logic [COUNT_BITS-1:0]     ntally_reg, btally_reg, itally_reg;
    logic signed [SUM_W-1:0]   dsum_reg, psum_reg, ssum_reg;
    logic signed [31:0]        dlow_reg, dhigh_reg, plow_reg, phigh_reg, slow_reg, shigh_reg;
    logic [ENERGY_W-1:0]       kin_reg;
    logic signed [ENERGY_W-1:0] pot_reg;
    logic [1:0]                qsel_reg;
    logic                      neg_reg;
    logic signed [31:0]        mean_reg;
    logic                      out_valid_reg;
    pbs_out_t                  out_reg;

    // datapath
    logic [63:0]               ke_raw;
    logic [ENERGY_W-1:0]       ke;
    logic [ENERGY_W:0]         kin_add;
    logic [51:0]               pm_raw;
    logic [ENERGY_W-1:0]       pm;
    logic signed [ENERGY_W:0]  pe;
    logic signed [ENERGY_W+1:0] pot_add;
    logic signed [ENERGY_W-1:0] pot_next;
    logic signed [31:0]        speed;
    logic                      sq_start, sq_done, div_start, div_done;
    logic [31:0]               sq_root;
    logic signed [SUM_W-1:0]   sum_sel;
    logic signed [31:0]        low_sel, high_sel;
    logic [SUM_W-1:0]          sum_mag, quot;
    logic signed [31:0]        mean_calc;
    logic                      out_free;

    assign ke_raw  = 64'(ph_reg) + 64'(pl_reg[62:32]);
    assign ke      = (|ke_raw[63:49]) ? KIN_MAX : ke_raw[48:1];
    assign kin_add = {1'b0, kin_reg} + {1'b0, ke};
    assign pm_raw  = 52'(qh_reg) + 52'(ql_reg[51:32]);
    assign pm      = (pm_raw > 52'(49'h1) << 47) ? ENERGY_W'(1) << 47 : pm_raw[ENERGY_W-1:0];
    assign pe      = item_reg.h_neg ? -$signed({1'b0, pm}) : $signed({1'b0, pm});
    assign pot_add = (ENERGY_W+2)'(pot_reg) + (ENERGY_W+2)'(pe);
    assign pot_next = (pot_add > (ENERGY_W+2)'(POT_MAX)) ? POT_MAX :
                      (pot_add < (ENERGY_W+2)'(POT_MIN)) ? POT_MIN :
                      pot_add[ENERGY_W-1:0];
    assign speed   = sq_root[31] ? VAL_MAX : $signed(sq_root);

    always_comb begin
        case (qsel_reg)
            QTY_DENSITY:  begin sum_sel = dsum_reg; low_sel = dlow_reg; high_sel = dhigh_reg; end
            QTY_PRESSURE: begin sum_sel = psum_reg; low_sel = plow_reg; high_sel = phigh_reg; end
            default:      begin sum_sel = ssum_reg; low_sel = slow_reg; high_sel = shigh_reg; end
        endcase
    end

    assign sum_mag = sum_sel[SUM_W-1] ? SUM_W'(-sum_sel) : SUM_W'(sum_sel);

    always_comb begin
        if (!neg_reg) begin
            mean_calc = (quot > SUM_W'(32'h7FFFFFFF)) ? VAL_MAX : $signed(quot[31:0]);
        end else begin
            mean_calc = (quot > SUM_W'(33'h80000000)) ? VAL_MIN : -$signed(quot[31:0]);
        end
    end

    assign q_ready   = (state_reg == ST_IDLE);
    assign sq_start  = (state_reg == ST_PROD);
    assign div_start = (state_reg == ST_DIV_START) && (ntally_reg != '0);
    assign out_free  = !out_valid_reg || m_ready;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    pbs_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (sq_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    pbs_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_mag),
        .divisor  (ntally_reg),
        .done     (div_done),
        .quotient (quot)
    );

    // datapath pipeline registers
    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) item_reg <= q_item;
        if (state_reg == ST_SQ) begin
            sqx_reg <= 64'(item_reg.abs_vx) * 64'(item_reg.abs_vx);
            sqy_reg <= 64'(item_reg.abs_vy) * 64'(item_reg.abs_vy);
            mh_reg  <= 63'(item_reg.mass) * 63'(item_reg.abs_h);
        end
        if (state_reg == ST_SUM) sq_reg <= sqx_reg + sqy_reg;
        if (state_reg == ST_PROD) begin
            pl_reg <= 63'(item_reg.mass) * 63'(sq_reg[31:0]);
            ph_reg <= 63'(item_reg.mass) * 63'(sq_reg[63:32]);
            ql_reg <= 52'(mh_reg[31:0]) * 52'(GRAVITY_Q16);
            qh_reg <= 51'(mh_reg[62:32]) * 51'(GRAVITY_Q16);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            qsel_reg      <= QTY_DENSITY;
            neg_reg       <= 1'b0;
            mean_reg      <= '0;
            out_valid_reg <= 1'b0;
            ntally_reg    <= '0;
            btally_reg    <= '0;
            itally_reg    <= '0;
            dsum_reg      <= '0;
            psum_reg      <= '0;
            ssum_reg      <= '0;
            dlow_reg      <= VAL_MAX;
            plow_reg      <= VAL_MAX;
            slow_reg      <= VAL_MAX;
            dhigh_reg     <= VAL_MIN;
            phigh_reg     <= VAL_MIN;
            shigh_reg     <= '0;
            kin_reg       <= '0;
            pot_reg       <= '0;
        end else begin
            // the emit state sets valid itself when the register frees up
            if (out_valid_reg && m_ready && state_reg != ST_EMIT) out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        qsel_reg <= QTY_DENSITY;
                        case (q_item.kind)
                            KIND_NORMAL: state_reg <= ST_SQ;
                            KIND_BOUNDARY: begin
                                if (btally_reg != COUNT_MAX)
                                    btally_reg <= btally_reg + COUNT_BITS'(1);
                            end
                            KIND_INACTIVE: begin
                                if (itally_reg != COUNT_MAX)
                                    itally_reg <= itally_reg + COUNT_BITS'(1);
                            end
                            default: ;
                        endcase
                        if (q_item.kind != KIND_NORMAL && q_item.last)
                            state_reg <= ST_DIV_START;
                    end
                end
                ST_SQ:   state_reg <= ST_SUM;
                ST_SUM:  state_reg <= ST_PROD;
                ST_PROD: state_reg <= ST_ACC;
                ST_ACC: begin
                    if (ntally_reg != COUNT_MAX)
                        ntally_reg <= ntally_reg + COUNT_BITS'(1);
                    dsum_reg <= sat_add(dsum_reg, item_reg.density);
                    psum_reg <= sat_add(psum_reg, item_reg.pressure);
                    if (item_reg.density < dlow_reg)   dlow_reg  <= item_reg.density;
                    if (item_reg.density > dhigh_reg)  dhigh_reg <= item_reg.density;
                    if (item_reg.pressure < plow_reg)  plow_reg  <= item_reg.pressure;
                    if (item_reg.pressure > phigh_reg) phigh_reg <= item_reg.pressure;
                    kin_reg   <= kin_add[ENERGY_W] ? KIN_MAX : kin_add[ENERGY_W-1:0];
                    pot_reg   <= pot_next;
                    state_reg <= ST_SQRT_WAIT;
                end
                ST_SQRT_WAIT: begin
                    if (sq_done) begin
                        ssum_reg <= sat_add(ssum_reg, speed);
                        if (speed < slow_reg)  slow_reg  <= speed;
                        if (speed > shigh_reg) shigh_reg <= speed;
                        state_reg <= item_reg.last ? ST_DIV_START : ST_IDLE;
                    end
                end
                ST_DIV_START: begin
                    neg_reg <= sum_sel[SUM_W-1];
                    if (ntally_reg == '0) begin
                        mean_reg  <= '0;
                        state_reg <= ST_EMIT;
                    end else begin
                        state_reg <= ST_DIV_WAIT;
                    end
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        mean_reg  <= mean_calc;
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        out_valid_reg           <= 1'b1;
                        out_reg.quantity        <= qsel_reg;
                        out_reg.mean_value      <= mean_reg;
                        out_reg.min_value       <= (ntally_reg == '0) ? '0 : low_sel;
                        out_reg.max_value       <= (ntally_reg == '0) ? '0 : high_sel;
                        out_reg.normal_count    <= ntally_reg;
                        out_reg.boundary_count  <= btally_reg;
                        out_reg.inactive_count  <= itally_reg;
                        out_reg.kinetic_total   <= kin_reg;
                        out_reg.potential_total <= pot_reg;
                        out_reg.last_of_run     <= (qsel_reg == QTY_SPEED);
                        if (qsel_reg == QTY_SPEED) begin
                            // batch closed: back to reset values
                            ntally_reg <= '0;
                            btally_reg <= '0;
                            itally_reg <= '0;
                            dsum_reg   <= '0;
                            psum_reg   <= '0;
                            ssum_reg   <= '0;
                            dlow_reg   <= VAL_MAX;
                            plow_reg   <= VAL_MAX;
                            slow_reg   <= VAL_MAX;
                            dhigh_reg  <= VAL_MIN;
                            phigh_reg  <= VAL_MIN;
                            shigh_reg  <= '0;
                            kin_reg    <= '0;
                            pot_reg    <= '0;
                            state_reg  <= ST_IDLE;
                        end else begin
                            qsel_reg  <= qsel_reg + 2'd1;
                            state_reg <= ST_DIV_START;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/particle_batch_statistics.sv
// Back end: a normal particle runs square, sum, product and accumulate steps,
// then waits on the bit-serial square root; other kinds are tallied in idle.
// The back end takes no new particle until it is done with the last one.
// Batch end divides once per mean when normal particles exist, then emits each.
// Reset: synchronous, active low; clears queue, tallies, sums, min/max, output valid.
// ============================================================================
// particle_batch_statistics: batch statistics over 2D particles
// Counts kinds and reduces density, pressure and speed to mean/min/max,
// with kinetic and potential energy totals, three results per batch.
// ============================================================================
module particle_batch_statistics (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pbs_pkg::pbs_in_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pbs_pkg::pbs_out_t   m_data
);
    import pbs_pkg::*;

    // front -> back request queue
    logic      q_valid;
    logic      q_ready;
    pbs_item_t q_item;

    // front: takes a request each cycle while the 2-deep queue has room,
    // classifies the kind and forms the magnitudes up front
    pbs_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item)
    );

    // back: multiplies, accumulates, then at batch end divides and emits
    // through its own output register, so results drain independently
    pbs_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_item  (q_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

>>> rtl/pbs_checker.sv
// ============================================================================
// pbs_checker: port-level assertions
// Watches the result channel of particle_batch_statistics.
// ============================================================================
`include "particle_batch_statistics_macros.svh"

module pbs_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input pbs_pkg::pbs_out_t  m_data
);
    import pbs_pkg::*;

    logic values_zero;

    assign values_zero = (m_data.mean_value == 0) && (m_data.min_value == 0) &&
                         (m_data.max_value == 0);

    `PBS_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_data))
    `PBS_ASSERT_NOW(a_last, m_valid, m_data.last_of_run == (m_data.quantity == QTY_SPEED))
    `PBS_ASSERT_NOW(a_empty, m_valid && m_data.normal_count == '0, values_zero)
    `PBS_ASSERT_RAW(a_rst, !aresetn, !m_valid)

endmodule

bind particle_batch_statistics pbs_checker u_pbs_checker (.*);

>>> bench/testbench.sv
// ============================================================================
// testbench: self-checking bench for particle_batch_statistics
// Streams particle batches through the block with random gaps on both sides.
// Each result is checked field by field against a built-in model of the
// batch tally, min/max/mean reduction and the energy totals.
// ============================================================================
module testbench;
    import pbs_pkg::*;

    localparam int  CLK_HALF    = 4;
    localparam int  RESET_CYCLES = 11;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_CYCLES = 250;   // margin for the batch-end divisions and emits
    localparam int  HOLD_CYCLES = 600;

    localparam longint SUM_HI = 64'sd2251799813685247;
    localparam longint SUM_LO = -64'sd2251799813685248;
    localparam longint POT_HI = 64'sd140737488355327;
    localparam longint POT_LO = -64'sd140737488355328;
    localparam longint unsigned KIN_HI = 64'd281474976710655;
    localparam longint unsigned GRAV = 64'd642908;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    pbs_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    pbs_out_t m_data;

    particle_batch_statistics DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // ------------------------------------------------------------------
    // model state of one open batch
    // ------------------------------------------------------------------
    longint unsigned normal_n, boundary_n, inactive_n;
    longint          dens_sum, dens_lo, dens_hi;
    longint          pres_sum, pres_lo, pres_hi;
    longint          spd_sum, spd_lo, spd_hi;
    longint unsigned kin_acc;
    longint          pot_acc;

    pbs_out_t stats_due[$];    // results still owed by the block

    int  mismatches;
    int  particles_sent;
    int  batches_closed;
    int  results_seen;
    int  cycles;
    bit  no_idle;              // stretches with no gaps on either side
    bit  hold_req;             // ask the receiver for a long hold-off

    // ------------------------------------------------------------------
    // clock, cycle limit
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("timeout after %0d cycles", cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'h1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // (a * b) >> 32, stuck at all ones if it leaves 64 bits
    function automatic longint unsigned mul_hi32(longint unsigned a, longint unsigned b);
        logic [127:0] p;
        p = ({64'd0, a} * {64'd0, b}) >> 32;
        if (p[127:64] != 0) return '1;
        return p[63:0];
    endfunction

    function automatic longint clamp_s(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint abs64(longint v);
        return (v < 0) ? -v : v;
    endfunction

    task automatic clear_batch();
        normal_n = 0; boundary_n = 0; inactive_n = 0;
        dens_sum = 0; pres_sum = 0; spd_sum = 0;
        dens_lo = 64'sh7FFFFFFF; pres_lo = 64'sh7FFFFFFF; spd_lo = 64'sh7FFFFFFF;
        dens_hi = -64'sh80000000; pres_hi = -64'sh80000000; spd_hi = 0;
        kin_acc = 0;
        pot_acc = 0;
    endtask

    task automatic fold_value(longint v, ref longint sum, ref longint lo, ref longint hi);
        sum = clamp_s(sum + v, SUM_LO, SUM_HI);
        if (v < lo) lo = v;
        if (v > hi) hi = v;
    endtask

    function automatic pbs_out_t batch_result(logic [1:0] qty, longint sum, longint lo,
                                              longint hi);
        pbs_out_t r;
        longint   mean;
        mean = 0;
        if (normal_n > 0) begin
            mean = clamp_s(sum / longint'(normal_n), -64'sh80000000, 64'sh7FFFFFFF);
        end else begin
            lo = 0;
            hi = 0;
        end
        r.quantity        = qty;
        r.mean_value      = mean[31:0];
        r.min_value       = lo[31:0];
        r.max_value       = hi[31:0];
        r.normal_count    = normal_n[COUNT_BITS-1:0];
        r.boundary_count  = boundary_n[COUNT_BITS-1:0];
        r.inactive_count  = inactive_n[COUNT_BITS-1:0];
        r.kinetic_total   = kin_acc[ENERGY_W-1:0];
        r.potential_total = pot_acc[ENERGY_W-1:0];
        r.last_of_run     = (qty == QTY_SPEED);
        return r;
    endfunction

    // fold one accepted particle into the batch; queue three results on close
    task automatic absorb_particle(pbs_in_t p);
        longint          vx, vy, h;
        longint unsigned sq, spd, ke, pm;
        longint          pe;
        case (p.particle_kind)
            KIND_NORMAL: begin
                vx = longint'(p.velocity_x);
                vy = longint'(p.velocity_y);
                h  = longint'(p.height);
                sq = longint'(abs64(vx)) * longint'(abs64(vx))
                   + longint'(abs64(vy)) * longint'(abs64(vy));
                spd = int_sqrt(sq);
                if (spd > 64'h7FFFFFFF) spd = 64'h7FFFFFFF;
                if (normal_n < COUNT_MAX) normal_n++;
                fold_value(longint'(p.density), dens_sum, dens_lo, dens_hi);
                fold_value(longint'(p.pressure), pres_sum, pres_lo, pres_hi);
                fold_value(longint'(spd), spd_sum, spd_lo, spd_hi);
                ke = mul_hi32({33'd0, p.mass}, sq) >> 1;
                if (ke > KIN_HI) ke = KIN_HI;
                kin_acc += ke;
                if (kin_acc > KIN_HI) kin_acc = KIN_HI;
                pm = mul_hi32({33'd0, p.mass} * longint'(abs64(h)), GRAV);
                if (pm > longint'(POT_HI) + 1) pm = longint'(POT_HI) + 1;
                pe = (h < 0) ? -longint'(pm) : longint'(pm);
                pot_acc = clamp_s(pot_acc + pe, POT_LO, POT_HI);
            end
            KIND_BOUNDARY: if (boundary_n < COUNT_MAX) boundary_n++;
            KIND_INACTIVE: if (inactive_n < COUNT_MAX) inactive_n++;
            default: ;
        endcase
        if (p.last_particle) begin
            stats_due.push_back(batch_result(QTY_DENSITY, dens_sum, dens_lo, dens_hi));
            stats_due.push_back(batch_result(QTY_PRESSURE, pres_sum, pres_lo, pres_hi));
            stats_due.push_back(batch_result(QTY_SPEED, spd_sum, spd_lo, spd_hi));
            batches_closed++;
            clear_batch();
        end
    endtask

    // ------------------------------------------------------------------
    // sender: one request per call, valid held across back-to-back requests
    // ------------------------------------------------------------------
    task automatic send_particle(pbs_in_t p);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= p;
        do @(posedge aclk); while (!s_ready);
        particles_sent++;
        absorb_particle(p);
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7FFFFFFF;
            2: return 32'h80000000;
            3: return 32'd0;
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    function automatic pbs_in_t make_particle(pbs_kind_t k, logic last);
        pbs_in_t p;
        p.particle_kind = k;
        p.density       = pick_word();
        p.pressure      = pick_word();
        p.velocity_x    = pick_word();
        p.velocity_y    = pick_word();
        p.mass          = ($urandom_range(0, 2) == 0) ? 31'($urandom) : 31'($urandom_range(0, 32'h40000));
        p.height        = pick_word();
        p.last_particle = last;
        return p;
    endfunction

    function automatic pbs_in_t fixed_particle(pbs_kind_t k, logic [31:0] d, logic [31:0] pr,
                                               logic [31:0] vx, logic [31:0] vy,
                                               logic [30:0] m, logic [31:0] h, logic last);
        pbs_in_t p;
        p.particle_kind = k;
        p.density = d; p.pressure = pr;
        p.velocity_x = vx; p.velocity_y = vy;
        p.mass = m; p.height = h;
        p.last_particle = last;
        return p;
    endfunction

    // ------------------------------------------------------------------
    // receiver: random ready gaps, with a long hold-off on request
    // ------------------------------------------------------------------
    initial begin : receiver
        int gap;
        m_ready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            gap = no_idle ? 0 : $urandom_range(0, 9);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // ------------------------------------------------------------------
    // result checker
    // ------------------------------------------------------------------
    task automatic report(string what, longint unsigned got, longint unsigned want);
        mismatches++;
        $display("[%0d] mismatch %s: got 0x%0h want 0x%0h", cycles, what, got, want);
    endtask

    always @(posedge aclk) begin : result_check
        pbs_out_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (stats_due.size() == 0) begin
                report("unexpected result", m_data.quantity, 0);
            end else begin
                want = stats_due.pop_front();
                if (m_data.quantity != want.quantity)
                    report("quantity", m_data.quantity, want.quantity);
                if (m_data.mean_value != want.mean_value)
                    report("mean_value", m_data.mean_value, want.mean_value);
                if (m_data.min_value != want.min_value)
                    report("min_value", m_data.min_value, want.min_value);
                if (m_data.max_value != want.max_value)
                    report("max_value", m_data.max_value, want.max_value);
                if (m_data.normal_count != want.normal_count)
                    report("normal_count", m_data.normal_count, want.normal_count);
                if (m_data.boundary_count != want.boundary_count)
                    report("boundary_count", m_data.boundary_count, want.boundary_count);
                if (m_data.inactive_count != want.inactive_count)
                    report("inactive_count", m_data.inactive_count, want.inactive_count);
                if (m_data.kinetic_total != want.kinetic_total)
                    report("kinetic_total", m_data.kinetic_total, want.kinetic_total);
                if (m_data.potential_total != want.potential_total)
                    report("potential_total", m_data.potential_total, want.potential_total);
                if (m_data.last_of_run != want.last_of_run)
                    report("last_of_run", m_data.last_of_run, want.last_of_run);
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    // field extremes, every kind, speed clamp, energy saturation
    task automatic test_directed();
        // lone normal particle, all zero
        send_particle(fixed_particle(KIND_NORMAL, 0, 0, 0, 0, 0, 0, 1'b1));
        // extremes: max/min values, speed clamp at full negative velocity
        send_particle(fixed_particle(KIND_NORMAL, 32'h7FFFFFFF, 32'h80000000,
                                     32'h80000000, 32'h80000000, 31'h7FFFFFFF,
                                     32'h7FFFFFFF, 1'b0));
        send_particle(fixed_particle(KIND_NORMAL, 32'h80000000, 32'h7FFFFFFF,
                                     32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF,
                                     32'h80000000, 1'b0));
        send_particle(fixed_particle(KIND_BOUNDARY, 32'hFFFFFFFF, 32'hFFFFFFFF,
                                     32'hFFFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF,
                                     32'hFFFFFFFF, 1'b0));
        send_particle(fixed_particle(KIND_INACTIVE, 0, 0, 0, 0, 0, 0, 1'b0));
        send_particle(fixed_particle(KIND_NORMAL, 32'h00010000, 32'hFFFF0000,
                                     32'h00030000, 32'h00040000, 31'h00010000,
                                     32'hFFFE0000, 1'b1));
        // potential saturating high, several heavy particles at max height
        repeat (3) send_particle(fixed_particle(KIND_NORMAL, 1, 1, 0, 0, 31'h7FFFFFFF,
                                               32'h7FFFFFFF, 1'b0));
        send_particle(fixed_particle(KIND_NORMAL, 2, 2, 1, 1, 31'h7FFFFFFF,
                                     32'h7FFFFFFF, 1'b1));
        // potential saturating low
        repeat (3) send_particle(fixed_particle(KIND_NORMAL, 5, 5, 0, 0, 31'h7FFFFFFF,
                                               32'h80000000, 1'b0));
        send_particle(fixed_particle(KIND_NORMAL, 7, 7, 0, 0, 31'h7FFFFFFF,
                                     32'h80000000, 1'b1));
        // batch without normal particles: values report as zero
        send_particle(fixed_particle(KIND_BOUNDARY, 1, 1, 1, 1, 1, 1, 1'b0));
        send_particle(fixed_particle(KIND_INACTIVE, 1, 1, 1, 1, 1, 1, 1'b1));
        // ignored kind changes nothing but still closes the batch
        send_particle(fixed_particle(KIND_NORMAL, 32'h00020000, 3, 32'h00010000, 0,
                                     31'h00020000, 32'h00010000, 1'b0));
        send_particle(fixed_particle(KIND_IGNORED, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                     32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF,
                                     32'h7FFFFFFF, 1'b1));
        // batch made only of an ignored closing particle
        send_particle(fixed_particle(KIND_IGNORED, 0, 0, 0, 0, 0, 0, 1'b1));
    endtask

    // random batches, mostly normal particles; the last particle closes each batch
    task automatic send_random_batch();
        int        len;
        pbs_kind_t k;
        len = $urandom_range(1, 6);
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 9))
                0, 1:    k = KIND_BOUNDARY;
                2:       k = KIND_INACTIVE;
                3:       k = KIND_IGNORED;
                default: k = KIND_NORMAL;
            endcase
            send_particle(make_particle(k, (i == len - 1)));
        end
    endtask

    task automatic test_random();
        while (particles_sent < 130) begin
            no_idle = ($urandom_range(0, 5) == 0);
            send_random_batch();
        end
        no_idle = 1'b0;
    endtask

    // receiver holds off while batches keep coming, so the input stalls
    task automatic test_backpressure();
        hold_req = 1'b1;
        repeat (4) send_random_batch();
        send_particle(make_particle(KIND_NORMAL, 1'b1));
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        mismatches = 0; particles_sent = 0; batches_closed = 0; results_seen = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        clear_batch();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data  <= '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_backpressure();
        test_random();
        s_valid <= 1'b0;

        while (stats_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d particles in %0d batches, %0d results checked",
                 particles_sent, batches_closed, results_seen);
        $display("kinds, closing flags, value extremes, energy saturation, long output stall");
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/pbs_pkg.sv
rtl/pbs_front.sv
rtl/pbs_sqrt.sv
rtl/pbs_div.sv
rtl/pbs_back.sv
rtl/particle_batch_statistics.sv
rtl/pbs_checker.sv
bench/testbench.sv
